// ----- src/bti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

  localparam int DEF_MAX_X_POINTS = 16;
  localparam int DEF_MAX_Y_POINTS = 16;

  localparam int VAL_W     = 32;
  localparam int DIFF_W    = VAL_W + 1;
  localparam int W_FRAC    = 30;
  localparam int PROD_W    = DIFF_W + W_FRAC;
  localparam int STEP_W    = $clog2(W_FRAC + 1);
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    KIND_WR_X    = 2'd0,
    KIND_WR_Y    = 2'd1,
    KIND_WR_GRID = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_USED = 1'b0,
    CFG_Y_USED = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV_START,
    S_DIV_WAIT,
    S_GRID,
    S_LERP_START,
    S_LERP_WAIT,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_RND,
    L_SAT
  } lerp_state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [VAL_W-1:0]   write_value;
    logic signed [VAL_W-1:0]   query_x;
    logic signed [VAL_W-1:0]   query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic                    error_flag;
  } out_word_t;

endpackage
`default_nettype wire

// ----- src/bti_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bti_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bti_pkg::DIFF_W-1:0]  num_i,
  input  wire logic [bti_pkg::DIFF_W-1:0]  den_i,
  output logic                             done_o,
  output logic [bti_pkg::W_FRAC-1:0]       quo_o
);
  import bti_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [DIFF_W-1:0]   rem_q;
  logic [DIFF_W-1:0]   den_q;
  logic [W_FRAC-1:0]   quo_q;
  logic [DIFF_W:0]     rem_sh;
  logic [DIFF_W:0]     rem_sub;
  logic                ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(W_FRAC);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
      quo_q <= {quo_q[W_FRAC-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- src/bti_lerp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bti_lerp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [bti_pkg::VAL_W-1:0]  f0_i,
  input  wire logic signed [bti_pkg::VAL_W-1:0]  f1_i,
  input  wire logic [bti_pkg::W_FRAC-1:0]        w_i,
  output logic                                   done_o,
  output logic signed [bti_pkg::VAL_W-1:0]       res_o
);
  import bti_pkg::*;

  lerp_state_e               st_q, st_d;
  logic [STEP_W-1:0]         cnt_q;
  logic                      done_q;
  logic signed [VAL_W-1:0]   f0_q;
  logic [DIFF_W-1:0]         mag_q;
  logic                      neg_q;
  logic [W_FRAC-1:0]         w_q;
  logic [PROD_W-1:0]         acc_q;
  logic [DIFF_W-1:0]         r_q;
  logic signed [VAL_W-1:0]   res_q;
  logic signed [DIFF_W-1:0]  diff;
  logic [PROD_W-1:0]         rnd;
  logic signed [DIFF_W+1:0]  sum;
  logic signed [VAL_W-1:0]   sat;

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE:  if (start_i) st_d = L_MUL;
      L_MUL:   if (cnt_q == STEP_W'(1)) st_d = L_RND;
      L_RND:   st_d = L_SAT;
      L_SAT:   st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_comb begin
    diff = $signed({f1_i[VAL_W-1], f1_i}) - $signed({f0_i[VAL_W-1], f0_i});
    rnd  = acc_q + (PROD_W'(1) << (W_FRAC - 1));
    sum  = neg_q ? ($signed({{3{f0_q[VAL_W-1]}}, f0_q}) - $signed({2'b00, r_q}))
                 : ($signed({{3{f0_q[VAL_W-1]}}, f0_q}) + $signed({2'b00, r_q}));
    if (sum[DIFF_W+1:VAL_W-1] == '0 || sum[DIFF_W+1:VAL_W-1] == '1) begin
      sat = sum[VAL_W-1:0];
    end else if (sum[DIFF_W+1]) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == L_SAT);
      if (st_q == L_IDLE && start_i) begin
        cnt_q <= STEP_W'(W_FRAC);
      end else if (st_q == L_MUL) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  // shift-add, one weight bit per cycle, msb first
  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        if (start_i) begin
          f0_q  <= f0_i;
          neg_q <= diff[DIFF_W-1];
          mag_q <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
          w_q   <= w_i;
          acc_q <= '0;
        end
      end
      L_MUL: begin
        acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (w_q[W_FRAC-1] ? PROD_W'(mag_q) : '0);
        w_q   <= {w_q[W_FRAC-2:0], 1'b0};
      end
      L_RND:   r_q   <= rnd[PROD_W-1:W_FRAC];
      L_SAT:   res_q <= sat;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ----- src/bilinear_table_interpolator_core.sv -----
// Bilinear lookup over a grid of up to MAX_X_POINTS x MAX_Y_POINTS signed Q16.16
// values. Write words (kinds 0..2) load breakpoints and grid entries. A query
// word scans both breakpoint lists (one entry per cycle), runs a bit-serial
// divider per axis for the weight (skipped when the point is clamped to an end
// of that axis), reads four grid entries and runs three bit-serial interpolation
// steps, so query time is bound by the shared divider and multiplier. A query
// with a non-increasing list stops after the scan. The result word is held in
// an output register; writes are taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_table_interpolator_core #(
  parameter int MAX_X_POINTS = bti_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bti_pkg::DEF_MAX_Y_POINTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire bti_pkg::in_word_t              in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bti_pkg::out_word_t                  out_word_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bti_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bti_pkg::CNT_W-1:0]      cfg_data_i
);
  import bti_pkg::*;

  localparam int XW   = $clog2(MAX_X_POINTS);
  localparam int YW   = $clog2(MAX_Y_POINTS);
  localparam int GN   = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GW   = $clog2(GN);
  localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int KW   = $clog2(MAXP + 1);

  logic signed [VAL_W-1:0] xbp_mem [MAX_X_POINTS];
  logic signed [VAL_W-1:0] ybp_mem [MAX_Y_POINTS];
  logic signed [VAL_W-1:0] grid_mem [GN];
  logic signed [VAL_W-1:0] xbp_rd_q, ybp_rd_q, grid_rd_q;

  logic [CNT_W-1:0] x_used_q, y_used_q;
  logic [KW-1:0]    nx, ny, n_cur;

  state_e           state_q, state_d;
  logic             axis_q, axis_d;
  logic [KW-1:0]    k_q, k_d, kd_q, kd_d;
  logic             dv_q, dv_d;
  logic [2:0]       g_q, g_d;
  logic [1:0]       lstep_q, lstep_d;
  logic             out_valid_q, out_load;
  out_word_t        out_word_q;

  logic in_acc;
  logic signed [VAL_W-1:0] qx_q, qy_q, q_cur, bp;
  logic signed [VAL_W-1:0] prev_q, lo_val_q, hi_val_q;
  logic [KW-1:0]    lo_idx_q;
  logic             found_q, below_q, err_q;
  logic [KW-1:0]    nl_lo_idx;
  logic signed [VAL_W-1:0] nl_lo_val, nl_hi_val;
  logic             nl_found, nl_below, nl_err, scan_last;
  logic             ax_zero;
  logic [KW-1:0]    ax_lo, ax_hi;
  logic [DIFF_W-1:0] ax_t, ax_d;

  logic [XW-1:0]    xlo_q, xhi_q;
  logic [YW-1:0]    ylo_q, yhi_q;
  logic [DIFF_W-1:0] tx_q, dx_q, ty_q, dy_q;
  logic             zx_q, zy_q, cur_zero;
  logic [W_FRAC-1:0] wx_q, wy_q;
  logic [GW-1:0]    grid_raddr, grid_waddr;
  logic signed [VAL_W-1:0] f00_q, f01_q, f10_q, f11_q, fa_q, fb_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic             res_err_q;

  logic                    div_start, div_done;
  logic [W_FRAC-1:0]       div_quo;
  logic                    lerp_start, lerp_done;
  logic signed [VAL_W-1:0] lerp_f0, lerp_f1, lerp_res;
  logic [W_FRAC-1:0]       lerp_w;

  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_used_q <= CNT_RESET;
      y_used_q <= CNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_X_USED: x_used_q <= cfg_data_i;
        CFG_Y_USED: y_used_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (x_used_q == '0) nx = KW'(1);
    else if (int'(x_used_q) > MAX_X_POINTS) nx = KW'(MAX_X_POINTS);
    else nx = KW'(x_used_q);
    if (y_used_q == '0) ny = KW'(1);
    else if (int'(y_used_q) > MAX_Y_POINTS) ny = KW'(MAX_Y_POINTS);
    else ny = KW'(y_used_q);
  end

  // tables
  assign grid_waddr = GW'(int'(in_word_i.row_index) * MAX_X_POINTS
                          + int'(in_word_i.col_index));

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.kind == KIND_WR_X
        && int'(in_word_i.col_index) < MAX_X_POINTS) begin
      xbp_mem[XW'(in_word_i.col_index)] <= in_word_i.write_value;
    end
    if (in_acc && in_word_i.kind == KIND_WR_Y
        && int'(in_word_i.row_index) < MAX_Y_POINTS) begin
      ybp_mem[YW'(in_word_i.row_index)] <= in_word_i.write_value;
    end
    if (in_acc && in_word_i.kind == KIND_WR_GRID
        && int'(in_word_i.row_index) < MAX_Y_POINTS
        && int'(in_word_i.col_index) < MAX_X_POINTS) begin
      grid_mem[grid_waddr] <= in_word_i.write_value;
    end
    xbp_rd_q  <= xbp_mem[k_q[XW-1:0]];
    ybp_rd_q  <= ybp_mem[k_q[YW-1:0]];
    grid_rd_q <= grid_mem[grid_raddr];
  end

  always_comb begin
    case (g_q[1:0])
      2'd0:    grid_raddr = GW'(int'(ylo_q) * MAX_X_POINTS + int'(xlo_q));
      2'd1:    grid_raddr = GW'(int'(ylo_q) * MAX_X_POINTS + int'(xhi_q));
      2'd2:    grid_raddr = GW'(int'(yhi_q) * MAX_X_POINTS + int'(xlo_q));
      default: grid_raddr = GW'(int'(yhi_q) * MAX_X_POINTS + int'(xhi_q));
    endcase
  end

  // breakpoint scan: order check and bracket search
  always_comb begin
    n_cur     = axis_q ? ny : nx;
    bp        = axis_q ? ybp_rd_q : xbp_rd_q;
    q_cur     = axis_q ? qy_q : qx_q;
    nl_lo_idx = lo_idx_q;
    nl_lo_val = lo_val_q;
    nl_hi_val = hi_val_q;
    nl_found  = found_q;
    nl_below  = below_q;
    nl_err    = err_q;
    if (kd_q == '0) begin
      nl_below  = (q_cur <= bp);
      nl_lo_idx = '0;
      nl_lo_val = bp;
      nl_hi_val = bp;
      nl_found  = 1'b0;
    end else begin
      if (bp <= prev_q) nl_err = 1'b1;
      if (bp <= q_cur) begin
        nl_lo_idx = kd_q;
        nl_lo_val = bp;
      end else if (!found_q) begin
        nl_hi_val = bp;
        nl_found  = 1'b1;
      end
    end
    scan_last = (state_q == S_SCAN) && dv_q && (kd_q == n_cur - KW'(1));
    ax_zero   = nl_below || !nl_found;
    ax_lo     = nl_below ? '0 : nl_lo_idx;
    ax_hi     = ax_zero ? ax_lo : ax_lo + KW'(1);
    ax_t      = DIFF_W'($signed({q_cur[VAL_W-1], q_cur})
                        - $signed({nl_lo_val[VAL_W-1], nl_lo_val}));
    ax_d      = DIFF_W'($signed({nl_hi_val[VAL_W-1], nl_hi_val})
                        - $signed({nl_lo_val[VAL_W-1], nl_lo_val}));
    cur_zero  = axis_q ? zy_q : zx_q;
  end

  always_comb begin
    case (lstep_q)
      2'd0: begin
        lerp_f0 = f00_q;
        lerp_f1 = f01_q;
        lerp_w  = wx_q;
      end
      2'd1: begin
        lerp_f0 = f10_q;
        lerp_f1 = f11_q;
        lerp_w  = wx_q;
      end
      default: begin
        lerp_f0 = fa_q;
        lerp_f1 = fb_q;
        lerp_w  = wy_q;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    k_d        = k_q;
    dv_d       = 1'b0;
    kd_d       = kd_q;
    g_d        = g_q;
    lstep_d    = lstep_q;
    div_start  = 1'b0;
    lerp_start = 1'b0;
    out_load   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_word_i.kind == KIND_QUERY) begin
          state_d = S_SCAN;
          axis_d  = 1'b0;
          k_d     = '0;
        end
      end
      S_SCAN: begin
        if (k_q < n_cur) begin
          k_d  = k_q + KW'(1);
          dv_d = 1'b1;
          kd_d = k_q;
        end
        if (scan_last) begin
          dv_d = 1'b0;
          k_d  = '0;
          if (!axis_q) begin
            axis_d = 1'b1;
          end else begin
            axis_d  = 1'b0;
            state_d = nl_err ? S_FINISH : S_DIV_START;
          end
        end
      end
      S_DIV_START: begin
        if (cur_zero) begin
          axis_d = 1'b1;
          if (axis_q) begin
            state_d = S_GRID;
            g_d     = '0;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          axis_d = 1'b1;
          if (axis_q) begin
            state_d = S_GRID;
            g_d     = '0;
          end else begin
            state_d = S_DIV_START;
          end
        end
      end
      S_GRID: begin
        g_d = g_q + 3'd1;
        if (g_q == 3'd4) begin
          state_d = S_LERP_START;
          lstep_d = '0;
        end
      end
      S_LERP_START: begin
        lerp_start = 1'b1;
        state_d    = S_LERP_WAIT;
      end
      S_LERP_WAIT: begin
        if (lerp_done) begin
          if (lstep_q == 2'd2) begin
            state_d = S_FINISH;
          end else begin
            lstep_d = lstep_q + 2'd1;
            state_d = S_LERP_START;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      k_q         <= '0;
      kd_q        <= '0;
      dv_q        <= 1'b0;
      g_q         <= '0;
      lstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      k_q     <= k_d;
      kd_q    <= kd_d;
      dv_q    <= dv_d;
      g_q     <= g_d;
      lstep_q <= lstep_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.kind == KIND_QUERY) begin
      qx_q  <= in_word_i.query_x;
      qy_q  <= in_word_i.query_y;
      err_q <= 1'b0;
    end
    if (state_q == S_SCAN && dv_q) begin
      prev_q   <= bp;
      lo_idx_q <= nl_lo_idx;
      lo_val_q <= nl_lo_val;
      hi_val_q <= nl_hi_val;
      found_q  <= nl_found;
      below_q  <= nl_below;
      err_q    <= nl_err;
    end
    if (scan_last) begin
      if (!axis_q) begin
        xlo_q <= XW'(ax_lo);
        xhi_q <= XW'(ax_hi);
        tx_q  <= ax_t;
        dx_q  <= ax_d;
        zx_q  <= ax_zero;
      end else begin
        ylo_q <= YW'(ax_lo);
        yhi_q <= YW'(ax_hi);
        ty_q  <= ax_t;
        dy_q  <= ax_d;
        zy_q  <= ax_zero;
        if (nl_err) begin
          res_val_q <= '0;
          res_err_q <= 1'b1;
        end
      end
    end
    if ((state_q == S_DIV_START && cur_zero) || (state_q == S_DIV_WAIT && div_done)) begin
      if (axis_q) wy_q <= cur_zero ? '0 : div_quo;
      else        wx_q <= cur_zero ? '0 : div_quo;
    end
    if (state_q == S_GRID) begin
      case (g_q)
        3'd1:    f00_q <= grid_rd_q;
        3'd2:    f01_q <= grid_rd_q;
        3'd3:    f10_q <= grid_rd_q;
        3'd4:    f11_q <= grid_rd_q;
        default: ;
      endcase
    end
    if (state_q == S_LERP_WAIT && lerp_done) begin
      case (lstep_q)
        2'd0: fa_q <= lerp_res;
        2'd1: fb_q <= lerp_res;
        default: begin
          res_val_q <= lerp_res;
          res_err_q <= 1'b0;
        end
      endcase
    end
    if (out_load) begin
      out_word_q.interp_value <= res_val_q;
      out_word_q.error_flag   <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  bti_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (axis_q ? ty_q : tx_q),
    .den_i   (axis_q ? dy_q : dx_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  bti_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .f0_i    (lerp_f0),
    .f1_i    (lerp_f1),
    .w_i     (lerp_w),
    .done_o  (lerp_done),
    .res_o   (lerp_res)
  );

endmodule
`default_nettype wire

// ----- src/bti_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bti_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire bti_pkg::in_word_t              in_word_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire bti_pkg::out_word_t             out_word_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [bti_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [bti_pkg::CNT_W-1:0]      cfg_data_i
);
  import bti_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error_flag |-> out_word_o.interp_value == '0)
    else $error("error word with nonzero value");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.kind == KIND_QUERY |=> !in_ready_o)
    else $error("ready right after a query");

endmodule

bind bilinear_table_interpolator_core bti_checker u_bti_checker (.*);
`default_nettype wire
